>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the sorted insert priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

>>> hw/rtl/sipq_pkg.sv
// Package with field widths, codes and controller/datapath link types of the queue.
package sipq_pkg;

   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int CAP_W    = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the accepted transaction
      logic rd_en;      // read the memory
      logic rd_fwd;     // read at the next position, else one below it
      logic pos_dec;
      logic pos_inc;
      logic wr_en;      // write the memory
      logic wr_prev;    // write one below the position, else at it
      logic wr_key;     // write the held key, else the read data
      logic grab_head;  // capture the read data as the removed key
      logic fill_inc;
      logic fill_dec;
      logic out_load;   // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic gt;         // read data is greater than the held key
      logic pos_one;
      logic fill_one;
      logic pos_last;   // position is the last held entry
      logic out_free;   // result register can take a new result
   } stat_type;

endpackage

>>> hw/rtl/sipq_intf.sv
// Channel interfaces of the queue: request, response and capacity write.
interface sipq_req_if import sipq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             operation;
   logic [KEY_W-1:0] key;

   modport source (output valid, output operation, output key, input ready);
   modport sink (input valid, input operation, input key, output ready);
endinterface

interface sipq_rsp_if import sipq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [KEY_W-1:0]    removed_key;
   logic [COUNT_W-1:0]  count;

   modport source (output valid, output status, output removed_key, output count,
                   input ready);
   modport sink (input valid, input status, input removed_key, input count,
                 output ready);
endinterface

interface sipq_csr_if import sipq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/sipq_ctrl.sv
// Controller state machine that sequences inserts and removes over the key memory.
module sipq_ctrl import sipq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_operation,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_INS_RD   = 8'b0000_0010,
      S_INS_CMP  = 8'b0000_0100,
      S_PLACE    = 8'b0000_1000,
      S_RM_RD    = 8'b0001_0000,
      S_RM_HEAD  = 8'b0010_0000,
      S_RM_SHIFT = 8'b0100_0000,
      S_DONE     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_operation == OP_INSERT) begin
                  if (stat.full) begin
                     state_in = S_DONE;
                  end else if (stat.empty) begin
                     state_in = S_PLACE;
                  end else begin
                     state_in = S_INS_RD;
                  end
               end else begin
                  state_in = stat.empty ? S_DONE : S_RM_RD;
               end
            end
         end
         S_INS_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_INS_CMP;
         end
         S_INS_CMP: begin
            cmd.wr_en = 1'b1;
            if (stat.gt) begin
               cmd.pos_dec = 1'b1;
               if (stat.pos_one) begin
                  state_in = S_PLACE;
               end else begin
                  cmd.rd_en = 1'b1;
               end
            end else begin
               cmd.wr_key   = 1'b1;
               cmd.fill_inc = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_PLACE: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_key   = 1'b1;
            cmd.fill_inc = 1'b1;
            state_in     = S_DONE;
         end
         S_RM_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_fwd = 1'b1;
            state_in   = S_RM_HEAD;
         end
         S_RM_HEAD: begin
            cmd.grab_head = 1'b1;
            if (stat.fill_one) begin
               cmd.fill_dec = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.pos_inc = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_fwd  = 1'b1;
               state_in    = S_RM_SHIFT;
            end
         end
         S_RM_SHIFT: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_prev = 1'b1;
            if (stat.pos_last) begin
               cmd.fill_dec = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.pos_inc = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_fwd  = 1'b1;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/sipq_dpath.sv
// Datapath of the queue: key memory, position and fill counters, capacity and result register.
module sipq_dpath import sipq_pkg::*; #(
   parameter int DEPTH     = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   sipq_req_if.sink   req,
   sipq_rsp_if.source rsp,
   sipq_csr_if.sink   csr,
   input  cmd_type  cmd,
   output stat_type stat
);

   localparam int AW   = $clog2(DEPTH);
   localparam int FW   = $clog2(DEPTH + 1);
   localparam int CMPW = (FW > CAP_W) ? FW : CAP_W;

   logic [KEY_WIDTH-1:0] mem [DEPTH];

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] rdata_ff;
   logic [AW-1:0]        pos_ff, pos_in;
   logic [FW-1:0]        fill_ff, fill_in;
   logic [CAP_W-1:0]     cap_ff;
   logic [STATUS_W-1:0]  status_ff;
   logic [KEY_W-1:0]     removed_ff;
   logic                 out_valid_ff;
   logic [STATUS_W-1:0]  out_status_ff;
   logic [KEY_W-1:0]     out_key_ff;
   logic [COUNT_W-1:0]   out_count_ff;

   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   logic [KEY_WIDTH-1:0] wr_data;

   always_comb begin
      pos_in = pos_ff;
      if (cmd.load) begin
         pos_in = (req.operation == OP_REMOVE) ? '0 : fill_ff[AW-1:0];
      end else if (cmd.pos_dec) begin
         pos_in = pos_ff - AW'(1);
      end else if (cmd.pos_inc) begin
         pos_in = pos_ff + AW'(1);
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.fill_inc) begin
         fill_in = fill_ff + FW'(1);
      end else if (cmd.fill_dec) begin
         fill_in = fill_ff - FW'(1);
      end
   end

   assign rd_addr = cmd.rd_fwd ? pos_in : pos_in - AW'(1);
   assign wr_addr = cmd.wr_prev ? pos_ff - AW'(1) : pos_ff;
   assign wr_data = cmd.wr_key ? key_ff : rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         cap_ff       <= CAP_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (csr.valid) begin
            cap_ff <= csr.data;
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.load) begin
         key_ff     <= KEY_WIDTH'(req.key);
         removed_ff <= '0;
         if (req.operation == OP_REMOVE) begin
            status_ff <= stat.empty ? ST_EMPTY : ST_OK;
         end else begin
            status_ff <= stat.full ? ST_FULL : ST_OK;
         end
      end
      if (cmd.grab_head) begin
         removed_ff <= KEY_W'(rdata_ff);
      end
      if (cmd.out_load) begin
         out_status_ff <= status_ff;
         out_key_ff    <= removed_ff;
         out_count_ff  <= COUNT_W'(fill_ff);
      end
   end

   assign stat.full     = (CMPW'(fill_ff) >= CMPW'(cap_ff)) || (fill_ff >= FW'(DEPTH));
   assign stat.empty    = (fill_ff == '0);
   assign stat.gt       = (rdata_ff > key_ff);
   assign stat.pos_one  = (pos_ff == AW'(1));
   assign stat.fill_one = (fill_ff == FW'(1));
   assign stat.pos_last = ((FW'(pos_ff) + FW'(1)) == fill_ff);
   assign stat.out_free = !out_valid_ff || rsp.ready;

   assign csr.ready       = 1'b1;
   assign rsp.valid       = out_valid_ff;
   assign rsp.status      = out_status_ff;
   assign rsp.removed_key = out_key_ff;
   assign rsp.count       = out_count_ff;

endmodule

>>> hw/rtl/sorted_insert_priority_queue_unit.sv
// Top level of the sorted insert priority queue: controller, datapath and checks.
//
//   Channel  Direction  Carries                              Transaction when
//   req      in         operation, key                       req.valid && req.ready
//   rsp      out        status, removed_key, count           rsp.valid && rsp.ready
//   csr      in         capacity (data)                      csr.valid && csr.ready
//
// One request is worked on at a time. An insert moves up each held entry greater than
// its key, and a remove moves every other held entry down by one; the memory moves
// one entry per cycle.
// The result register lets a new request enter while the last result still waits;
// a request finishes only once that register is free.
// Reset is synchronous: fill goes to zero, capacity to 16, the result register empties.
// The key memory itself is not cleared; only entries below the fill are read.
`include "assert_macros.svh"

module sorted_insert_priority_queue_unit import sipq_pkg::*; #(
   parameter int DEPTH     = 16,
   parameter int KEY_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   sipq_req_if.sink   req,
   sipq_rsp_if.source rsp,
   sipq_csr_if.sink   csr
);

   cmd_type  cmd;
   stat_type stat;
   logic     ctrl_ready;

   // The controller walks each transaction through its memory steps.
   sipq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req.valid),
      .req_operation (req.operation),
      .req_ready     (ctrl_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   assign req.ready = ctrl_ready;

   // The datapath holds the sorted keys in a memory and carries out the commands.
   sipq_dpath #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dpath (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr),
      .cmd   (cmd),
      .stat  (stat)
   );

   // An accepted request keeps the block busy for at least the next cycle.
   `ASSERT_CLK_RST(a_busy_after_accept, clock, reset, (req.valid && req.ready) |=> !req.ready, "request accepted while the previous one was still in progress")

   // Only a successful remove reports a nonzero key.
   `ASSERT_CLK_RST(a_key_zero_on_flag, clock, reset, (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.removed_key == '0), "flagged result carries a nonzero removed key")

   // Neither is the memory written nor the result register loaded while the block waits for a request.
   `ASSERT_CLK(a_no_write_idle, clock, (cmd.wr_en || cmd.out_load) |-> !req.ready, "memory write or result load while idle")

endmodule

>>> tb/sv/tb_sorted_insert_priority_queue_unit.sv
// Self-checking testbench for the sorted insert priority queue unit.
module tb_sorted_insert_priority_queue_unit;
   import sipq_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 630;
   localparam int MAX_REPORTS  = 10;
   localparam int END_CYCLES   = 40;

   // One response transaction, as the predictor expects it.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [KEY_W-1:0]    removed_key;
      logic [COUNT_W-1:0]  count;
   } queue_result_type;

   // One row of the directed table. A row either writes the capacity or sends one
   // request; where typed is set, the result is given in the row itself instead of
   // being taken from the predictor.
   typedef struct packed {
      logic             is_cfg;
      logic [CAP_W-1:0] cap;
      logic             op;
      logic [KEY_W-1:0] key;
      logic             typed;
      queue_result_type want;
   } stim_row_type;

   // The receiver switches between steady acceptance, coin-flip stalls and long stalls.
   typedef enum logic [1:0] {RX_STEADY, RX_CHOPPY, RX_SPARSE} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sipq_req_if req_if ();
   sipq_rsp_if rsp_if ();
   sipq_csr_if csr_if ();

   sorted_insert_priority_queue_unit i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   // Predictor state: the held keys in ascending order and the capacity register.
   logic [KEY_W-1:0] held_keys[$];
   logic [CAP_W-1:0] model_capacity = CAP_RESET;

   // Results still owed by the block, oldest first.
   queue_result_type pending_results[$];

   int          mismatch_count = 0;
   int          burst_left     = 0;
   rx_mode_type rx_mode        = RX_STEADY;
   int          rx_mode_left   = 0;

   // The directed part walks the queue through its corner cases: a remove on an
   // empty queue, the largest and smallest keys, equal keys, a capacity lowered
   // below the fill, a capacity of zero, and finally a capacity above the depth.
   stim_row_type directed_rows [20] = '{
      '{1'b0, 5'd0,  OP_REMOVE, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0000_0000, 5'd0}},
      '{1'b0, 5'd0,  OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0000_0000, 5'd1}},
      '{1'b0, 5'd0,  OP_INSERT, 32'h0000_0000, 1'b1, '{ST_OK,    32'h0000_0000, 5'd2}},
      '{1'b0, 5'd0,  OP_INSERT, 32'h8000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 5'd0}},
      '{1'b0, 5'd0,  OP_INSERT, 32'h8000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 5'd0}},
      '{1'b0, 5'd0,  OP_INSERT, 32'h0000_0001, 1'b0, '{ST_OK,    32'h0000_0000, 5'd0}},
      '{1'b1, 5'd2,  OP_INSERT, 32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 5'd0}},
      '{1'b0, 5'd0,  OP_INSERT, 32'h1234_5678, 1'b1, '{ST_FULL,  32'h0000_0000, 5'd5}},
      '{1'b0, 5'd0,  OP_REMOVE, 32'hDEAD_BEEF, 1'b1, '{ST_OK,    32'h0000_0000, 5'd4}},
      '{1'b0, 5'd0,  OP_REMOVE, 32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 5'd0}},
      '{1'b0, 5'd0,  OP_REMOVE, 32'h5555_AAAA, 1'b0, '{ST_OK,    32'h0000_0000, 5'd0}},
      '{1'b0, 5'd0,  OP_INSERT, 32'h0000_0007, 1'b1, '{ST_FULL,  32'h0000_0000, 5'd2}},
      '{1'b0, 5'd0,  OP_REMOVE, 32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 5'd0}},
      '{1'b0, 5'd0,  OP_INSERT, 32'h0000_0007, 1'b0, '{ST_OK,    32'h0000_0000, 5'd0}},
      '{1'b1, 5'd0,  OP_INSERT, 32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 5'd0}},
      '{1'b0, 5'd0,  OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{ST_FULL,  32'h0000_0000, 5'd2}},
      '{1'b0, 5'd0,  OP_REMOVE, 32'hFFFF_FFFF, 1'b0, '{ST_OK,    32'h0000_0000, 5'd0}},
      '{1'b0, 5'd0,  OP_REMOVE, 32'h0000_0000, 1'b1, '{ST_OK,    32'hFFFF_FFFF, 5'd0}},
      '{1'b0, 5'd0,  OP_REMOVE, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0000_0000, 5'd0}},
      '{1'b1, 5'd31, OP_INSERT, 32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 5'd0}}
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one request to the predictor and returns the result it must cause.
   // An insert goes behind every held key that is less than or equal to it, so
   // equal keys leave in arrival order. The usable capacity never exceeds the depth.
   function automatic queue_result_type sorted_queue_apply(input logic op,
                                                            input logic [KEY_W-1:0] key);
      int               limit;
      int               pos;
      queue_result_type res;
      limit = (model_capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(model_capacity);
      res   = '{ST_OK, '0, '0};
      if (op == OP_INSERT) begin
         if (held_keys.size() >= limit) begin
            res.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < held_keys.size() && held_keys[pos] <= key) pos++;
            held_keys.insert(pos, key);
         end
      end else begin
         if (held_keys.size() == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.removed_key = held_keys.pop_front();
         end
      end
      res.count = COUNT_W'(held_keys.size());
      return res;
   endfunction

   // Keys are drawn from several pools so that duplicates, extremes and wide
   // random values all show up; the small pool makes equal keys common.
   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] key;
      case ($urandom_range(0, 3))
         0: key = $urandom_range(0, 7);
         1: begin
            case ($urandom_range(0, 3))
               0: key = 32'h0000_0000;
               1: key = 32'hFFFF_FFFF;
               2: key = 32'h8000_0000;
               default: key = 32'h7FFF_FFFF;
            endcase
         end
         default: key = $urandom();
      endcase
      return key;
   endfunction

   // Sends one request transaction. The task is entered and left at a falling edge.
   // Requests go out in bursts; between bursts the valid line drops low for a random pause.
   // On exit the valid line is still high, so a caller that wants to pause must
   // lower it before letting time pass.
   task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                               input logic typed, input queue_result_type want);
      queue_result_type predicted;
      if (burst_left == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 16);
      end
      req_if.valid     = 1'b1;
      req_if.operation = op;
      req_if.key       = key;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      predicted = sorted_queue_apply(op, key);
      pending_results.push_back(typed ? want : predicted);
      burst_left--;
      @(negedge clock);
   endtask

   // Stops the request stream and waits until every owed result has come back.
   task automatic drain_results();
      req_if.valid = 1'b0;
      burst_left   = 0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes the capacity register once the block is idle.
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      drain_results();
      csr_if.valid = 1'b1;
      csr_if.data  = value;
      @(posedge clock);
      while (csr_if.ready !== 1'b1) @(posedge clock);
      model_capacity = value;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // The receiver sets its ready line at every falling edge, following a mode that is
   // drawn at random and drawn anew whenever its random stretch runs out.
   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      = rx_mode_type'($urandom_range(0, 2));
         rx_mode_left = $urandom_range(8, 48);
      end
      rx_mode_left--;
      case (rx_mode)
         RX_STEADY: rsp_if.ready = 1'b1;
         RX_CHOPPY: rsp_if.ready = 1'($urandom_range(0, 1));
         default:   rsp_if.ready = ($urandom_range(0, 3) == 0);
      endcase
   end

   // Every response transaction is checked against the oldest owed result.
   always @(posedge clock) begin
      queue_result_type got;
      queue_result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got = '{rsp_if.status, rsp_if.removed_key, rsp_if.count};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected result status=%0d removed_key=%h count=%0d",
                        $realtime, got.status, got.removed_key, got.count);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.removed_key !== want.removed_key ||
                got.count !== want.count) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: status/key/count expected %0d/%h/%0d, got %0d/%h/%0d",
                           $realtime, want.status, want.removed_key, want.count,
                           got.status, got.removed_key, got.count);
            end
         end
      end
   end

   initial begin
      int               random_sent;
      int               phase_len;
      int               insert_weight;
      logic             op;
      logic [CAP_W-1:0] cap;

      req_if.valid     = 1'b0;
      req_if.operation = OP_INSERT;
      req_if.key       = '0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.data      = '0;
      random_sent      = 0;

      // Synchronous reset is held across rising edges and released at a falling edge.
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_cfg)
            write_capacity(directed_rows[i].cap);
         else
            send_request(directed_rows[i].op, directed_rows[i].key,
                         directed_rows[i].typed, directed_rows[i].want);
      end

      // Random phases. Each phase starts from an idle block with a fresh capacity,
      // which may fall below the current fill, and then leans toward filling,
      // draining or a balanced mix so that both the full and the empty queue occur.
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0: cap = 5'd0;
            1: cap = 5'd1;
            2: cap = CAP_W'(QUEUE_DEPTH);
            3: cap = ($urandom_range(0, 1) == 1) ? 5'd31 : CAP_W'($urandom_range(17, 30));
            default: cap = CAP_W'($urandom_range(2, 15));
         endcase
         write_capacity(cap);
         phase_len     = $urandom_range(15, 60);
         if (phase_len > RANDOM_ITEMS - random_sent)
            phase_len = RANDOM_ITEMS - random_sent;
         insert_weight = 25 * $urandom_range(1, 3);
         repeat (phase_len) begin
            op = ($urandom_range(0, 99) < insert_weight) ? OP_INSERT : OP_REMOVE;
            send_request(op, pick_key(), 1'b0, '0);
            random_sent++;
         end
      end

      drain_results();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Hard limit on the run, far above the slowest correct run.
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> sorted_insert_priority_queue_unit.f
+incdir+hw/rtl
hw/rtl/sipq_pkg.sv
hw/rtl/sipq_intf.sv
hw/rtl/sipq_ctrl.sv
hw/rtl/sipq_dpath.sv
hw/rtl/sorted_insert_priority_queue_unit.sv
tb/sv/tb_sorted_insert_priority_queue_unit.sv
